// ===== rtl/olq_pkg.sv =====
// ============================================================================
// olq_pkg
// Shared types and constants for the ordered list deque unit.
// ============================================================================
package olq_pkg;

	localparam int VALUE_W  = 32;
	localparam int OPCODE_W = 3;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_DEL_FRONT = 3'd3,
		OP_DEL_END   = 3'd4,
		OP_DEL_AT    = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Broadcast command seen by every cell of the chain.
	typedef struct packed {
		logic ins;
		logic del;
	} cell_cmd_t;

endpackage

// ===== rtl/olq_if.sv =====
// ============================================================================
// olq_req_if / olq_rsp_if
// Valid/ready channels carrying operation words and result words.
// ============================================================================
interface olq_req_if;
	logic                                valid;
	logic                                ready;
	logic [olq_pkg::OPCODE_W-1:0]        opcode;
	logic signed [olq_pkg::VALUE_W-1:0]  value;
	logic [olq_pkg::POS_W-1:0]           position;

	modport source (output valid, output opcode, output value, output position, input ready);
	modport sink (input valid, input opcode, input value, input position, output ready);
endinterface

interface olq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [olq_pkg::VALUE_W-1:0]  front_value;
	logic signed [olq_pkg::VALUE_W-1:0]  end_value;
	logic [olq_pkg::COUNT_W-1:0]         entry_count;
	logic [olq_pkg::STATUS_W-1:0]        status;

	modport source (output valid, output front_value, output end_value, output entry_count,
		output status, input ready);
	modport sink (input valid, input front_value, input end_value, input entry_count,
		input status, output ready);
endinterface

// ===== rtl/olq_cell.sv =====
// ============================================================================
// olq_cell
// One storage cell of the list chain. It holds, loads the inserted value,
// or takes the word of its left or right neighbor.
// ============================================================================
module olq_cell #(
	parameter int                IDX_W = 4,
	parameter logic [IDX_W-1:0]  POS   = '0
) (
	input  logic                               clk,
	input  olq_pkg::cell_cmd_t                 cmd,
	input  logic [IDX_W-1:0]                   idx,
	input  logic signed [olq_pkg::VALUE_W-1:0] ins_value,
	input  logic signed [olq_pkg::VALUE_W-1:0] left_value,
	input  logic signed [olq_pkg::VALUE_W-1:0] right_value,
	output logic signed [olq_pkg::VALUE_W-1:0] value
);

	logic signed [olq_pkg::VALUE_W-1:0] value_q;

	// Cells past the insert point shift right; cells at or past the delete
	// point shift left. Cells beyond the count may pick up stale words.
	always_ff @(posedge clk) begin
		if (cmd.ins && (POS == idx)) begin
			value_q <= ins_value;
		end else if (cmd.ins && (POS > idx)) begin
			value_q <= left_value;
		end else if (cmd.del && (POS >= idx)) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;

endmodule

// ===== rtl/ordered_list_deque_unit.sv =====
// ============================================================================
// ordered_list_deque_unit
// Bounded ordered list of signed 32-bit values built as a chain of cells.
// ============================================================================
// Usage:
// The req channel takes one operation word per handshake: an opcode (insert
// front, insert end, insert at, delete front, delete end, delete at), a value
// for inserts and a 1-based position for the positional operations. The rsp
// channel returns exactly one result word per operation: the front and end
// entries after the operation (zero when the list is empty), the entry count
// and a status (ok, full, empty or position out of range). A rejected
// operation leaves the list unchanged.
// The unit sustains one operation per cycle unless the receiver stalls:
// every cell shifts, loads or holds in the edge that accepts the word, and
// the output register reads the new chain as the middle stage advances.
// The end entry is picked by a one-hot select across the chain.
// When the receiver stalls, the result word holds in the output register,
// one more operation may complete into the middle stage, and then req.ready
// drops until the output register drains.
// Reset clears the count and the handshake state; cell contents are not
// reset since only cells below the count are ever reported.
// ============================================================================
module ordered_list_deque_unit #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	olq_req_if.sink     req,
	olq_rsp_if.source   rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// Common compare width for the count and the position, with headroom.
	localparam int CMP_W = ((CNT_W > olq_pkg::POS_W) ? CNT_W : olq_pkg::POS_W) + 1;

	logic [CNT_W-1:0]                   count_q;
	logic                               valid_s1;
	olq_pkg::status_t                   status_s1;
	logic                               out_valid_q;
	logic signed [olq_pkg::VALUE_W-1:0] front_q;
	logic signed [olq_pkg::VALUE_W-1:0] end_q;
	logic [olq_pkg::COUNT_W-1:0]        count_out_q;
	olq_pkg::status_t                   status_q;

	logic                               accept;
	logic                               advance;
	logic                               do_ins;
	logic                               do_del;
	logic [IDX_W-1:0]                   idx;
	olq_pkg::status_t                   status_d;
	olq_pkg::cell_cmd_t                 cmd;
	logic [CMP_W-1:0]                   cnt_x;
	logic [CMP_W-1:0]                   pos_x;
	logic [IDX_W-1:0]                   last_idx;
	logic signed [olq_pkg::VALUE_W-1:0] end_sel;
	logic [CMP_W-1:0]                   count_ext;

	logic signed [olq_pkg::VALUE_W-1:0] cell_val [CAPACITY];

	// Handshake: the middle stage advances when the output register is free or
	// being emptied; a word enters when the middle stage is empty or moves on.
	assign advance = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept = req.valid && req.ready;

	// Decode of the operation against the current count.
	always_comb begin
		cnt_x    = CMP_W'(count_q);
		pos_x    = CMP_W'(req.position);
		do_ins   = 1'b0;
		do_del   = 1'b0;
		idx      = '0;
		status_d = olq_pkg::ST_OK;
		case (olq_pkg::opcode_t'(req.opcode))
			olq_pkg::OP_INS_FRONT, olq_pkg::OP_INS_END, olq_pkg::OP_INS_AT: begin
				if (count_q >= CNT_W'(CAPACITY)) begin
					status_d = olq_pkg::ST_FULL;
				end else if (olq_pkg::opcode_t'(req.opcode) == olq_pkg::OP_INS_FRONT) begin
					do_ins = 1'b1;
				end else if (olq_pkg::opcode_t'(req.opcode) == olq_pkg::OP_INS_END) begin
					do_ins = 1'b1;
					idx    = IDX_W'(count_q);
				end else if ((pos_x == '0) || (pos_x > cnt_x + CMP_W'(1))) begin
					status_d = olq_pkg::ST_RANGE;
				end else begin
					do_ins = 1'b1;
					idx    = IDX_W'(pos_x - CMP_W'(1));
				end
			end
			olq_pkg::OP_DEL_FRONT, olq_pkg::OP_DEL_END, olq_pkg::OP_DEL_AT: begin
				if (count_q == '0) begin
					status_d = olq_pkg::ST_EMPTY;
				end else if (olq_pkg::opcode_t'(req.opcode) == olq_pkg::OP_DEL_FRONT) begin
					do_del = 1'b1;
				end else if (olq_pkg::opcode_t'(req.opcode) == olq_pkg::OP_DEL_END) begin
					do_del = 1'b1;
					idx    = IDX_W'(count_q - CNT_W'(1));
				end else if ((pos_x == '0) || (pos_x > cnt_x)) begin
					status_d = olq_pkg::ST_RANGE;
				end else begin
					do_del = 1'b1;
					idx    = IDX_W'(pos_x - CMP_W'(1));
				end
			end
			default: begin
				status_d = olq_pkg::ST_OK;
			end
		endcase
	end

	assign cmd.ins = accept && do_ins;
	assign cmd.del = accept && do_del;

	// The chain itself. The leftmost cell never shifts right and the
	// rightmost cell takes its own word on a delete.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [olq_pkg::VALUE_W-1:0] left_w;
		logic signed [olq_pkg::VALUE_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = req.value;
		end else begin : g_mid_l
			assign left_w = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_val[i];
		end else begin : g_mid_r
			assign right_w = cell_val[i+1];
		end
		olq_cell #(
			.IDX_W (IDX_W),
			.POS   (IDX_W'(i))
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.idx         (idx),
			.ins_value   (req.value),
			.left_value  (left_w),
			.right_value (right_w),
			.value       (cell_val[i])
		);
	end

	// Count and middle stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.del) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
		end
	end

	// End entry: one-hot select of the cell just below the count.
	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	always_comb begin
		end_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (IDX_W'(i) == last_idx) begin
				end_sel = end_sel | cell_val[i];
			end
		end
	end

	assign count_ext = CMP_W'(count_q);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			front_q     <= (count_q == '0) ? '0 : cell_val[0];
			end_q       <= (count_q == '0) ? '0 : end_sel;
			count_out_q <= count_ext[olq_pkg::COUNT_W-1:0];
			status_q    <= status_s1;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.front_value = front_q;
	assign rsp.end_value   = end_q;
	assign rsp.entry_count = count_out_q;
	assign rsp.status      = status_q;

endmodule

// ===== sim/tb_ordered_list_deque_unit.sv =====
// ============================================================================
// tb_ordered_list_deque_unit
// Self-checking bench for the ordered list deque unit. A short table of
// operation words covers the empty, single-entry and bad-position corners,
// then phases of random words grow, shrink, churn and hammer the list at its
// limits. A shadow list predicts the words the table does not type; the
// result channel is checked field by field in order of issue.
// ============================================================================
module tb_ordered_list_deque_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import olq_pkg::*;

	localparam int CAPACITY     = 16;
	localparam int RANDOM_WORDS = 1850;
	localparam int QUIET_LIMIT  = 400;
	localparam int MAX_REPORTS  = 60;

	// Opcodes 6 and 7 are not decoded; they must leave the list untouched.
	localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

	localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// Row flags: the expected word is either typed into the table or taken
	// from the shadow list.
	localparam bit TYPED      = 1'b1;
	localparam bit FROM_SHADOW = 1'b0;

	// What the unit reports about the list after one operation.
	typedef struct packed {
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] end_value;
		logic [COUNT_W-1:0]        entry_count;
		status_t                   status;
	} list_view_t;

	typedef struct {
		logic [OPCODE_W-1:0]       opcode;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
		bit                        typed;
		list_view_t                view;
	} plan_row_t;

	// Random mixes: each phase of the random part leans one way.
	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_CHURN, MIX_EDGES} mix_e;

	// Receiver patterns: free flow, a fixed cadence, a coin toss per cycle,
	// and a choke that raises ready only when its tick is a multiple of ten.
	typedef enum int {RX_FLOW, RX_CADENCE, RX_COIN, RX_CHOKE} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	olq_req_if req_ch ();
	olq_rsp_if rsp_ch ();

	ordered_list_deque_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the list. It is updated at the edge that accepts an
	// operation word, so it always reflects every word issued so far.
	logic signed [VALUE_W-1:0] shadow_cells [CAPACITY];
	int unsigned               shadow_count = 0;

	// Views still owed by the unit, oldest first.
	list_view_t list_views [$];
	plan_row_t  directed_plan [$];

	int error_count   = 0;
	int words_checked = 0;
	int burst_left    = 0;
	int quiet_cycles  = 0;

	task automatic report_error(input string what);
		if (error_count < MAX_REPORTS)
			$display("[%0t] MISMATCH at result word %0d: %s", $realtime, words_checked, what);
		error_count++;
	endtask

	// Applies one operation to the shadow list and returns the view the unit
	// must report. A rejected operation leaves the shadow list as it was.
	function automatic list_view_t list_apply(input logic [OPCODE_W-1:0] op,
			input logic signed [VALUE_W-1:0] value, input logic [POS_W-1:0] pos);
		list_view_t  view;
		int unsigned slot;
		int unsigned i;
		view.status = ST_OK;
		slot = 0;
		case (op)
			OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
				// A full list is flagged before the position is looked at.
				if (shadow_count >= CAPACITY) begin
					view.status = ST_FULL;
				end else if (op == OP_INS_END) begin
					slot = shadow_count;
				end else if (op == OP_INS_AT) begin
					if (pos == '0 || pos > shadow_count + 1)
						view.status = ST_RANGE;
					else
						slot = pos - 1;
				end
				if (view.status == ST_OK) begin
					for (i = shadow_count; i > slot; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[slot] = value;
					shadow_count++;
				end
			end
			OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT: begin
				// An empty list is flagged before the position is looked at.
				if (shadow_count == 0) begin
					view.status = ST_EMPTY;
				end else if (op == OP_DEL_END) begin
					slot = shadow_count - 1;
				end else if (op == OP_DEL_AT) begin
					if (pos == '0 || pos > shadow_count)
						view.status = ST_RANGE;
					else
						slot = pos - 1;
				end
				if (view.status == ST_OK) begin
					for (i = slot; i + 1 < shadow_count; i++)
						shadow_cells[i] = shadow_cells[i+1];
					shadow_count--;
				end
			end
			default: begin
				// Spare opcodes do nothing and report the list as it stands.
			end
		endcase
		if (shadow_count > 0) begin
			view.front_value = shadow_cells[0];
			view.end_value   = shadow_cells[shadow_count-1];
		end else begin
			view.front_value = '0;
			view.end_value   = '0;
		end
		view.entry_count = COUNT_W'(shadow_count);
		return view;
	endfunction

	task automatic add_row(input logic [OPCODE_W-1:0] op, input logic signed [VALUE_W-1:0] value,
			input logic [POS_W-1:0] pos, input bit typed, input logic signed [VALUE_W-1:0] front,
			input logic signed [VALUE_W-1:0] last, input logic [COUNT_W-1:0] count,
			input status_t st);
		plan_row_t row;
		row.opcode   = op;
		row.value    = value;
		row.position = pos;
		row.typed    = typed;
		row.view     = '{front_value: front, end_value: last, entry_count: count, status: st};
		directed_plan.push_back(row);
	endtask

	// Offers one operation word and waits for the handshake. The sender works
	// in bursts; before each burst it may drop valid for a random gap, and
	// some bursts are long with no gap at all. Valid is written once per edge,
	// so a word that follows straight on keeps valid high without a glitch.
	task automatic issue_word(input logic [OPCODE_W-1:0] op,
			input logic signed [VALUE_W-1:0] value, input logic [POS_W-1:0] pos,
			input bit typed, input list_view_t typed_view);
		int         gap;
		list_view_t shadow_view;
		if (burst_left == 0) begin
			if ($urandom_range(9) < 3) begin
				burst_left = $urandom_range(60, 20);
				gap = 0;
			end else begin
				burst_left = $urandom_range(12, 1);
				gap = $urandom_range(8);
			end
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid    <= 1'b1;
		req_ch.opcode   <= op;
		req_ch.value    <= value;
		req_ch.position <= pos;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		shadow_view = list_apply(op, value, pos);
		list_views.push_back(typed ? typed_view : shadow_view);
	endtask

	// Stimulus: reset, the directed table, then random phases, then drain.
	initial begin : stimulus
		logic [OPCODE_W-1:0]       op;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          pos;
		mix_e                      mix;
		int                        phase_left;
		int                        random_sent;
		int                        roll;
		int                        kind;
		int                        odd_pos_pct;
		bit                        grow_edge;
		bit                        is_insert;

		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.opcode   <= '0;
		req_ch.value    <= '0;
		req_ch.position <= '0;
		random_sent = 0;
		grow_edge   = 1'b0;

		// Empty list: every delete is flagged empty, even with a bad position,
		// and insert at accepts only position one.
		add_row(OP_DEL_FRONT, 0, 0, TYPED, 0, 0, 0, ST_EMPTY);
		add_row(OP_DEL_AT, 0, 1, TYPED, 0, 0, 0, ST_EMPTY);
		add_row(OP_INS_AT, 9, 0, TYPED, 0, 0, 0, ST_RANGE);
		add_row(OP_INS_AT, 9, 2, TYPED, 0, 0, 0, ST_RANGE);
		add_row(OP_SPARE_LO, VALUE_MAX, 31, TYPED, 0, 0, 0, ST_OK);
		// A single entry, then deleting it must bring both ends back to zero.
		add_row(OP_INS_FRONT, VALUE_MAX, 0, TYPED, VALUE_MAX, VALUE_MAX, 1, ST_OK);
		add_row(OP_DEL_FRONT, 0, 0, TYPED, 0, 0, 0, ST_OK);
		add_row(OP_INS_END, VALUE_MIN, 0, TYPED, VALUE_MIN, VALUE_MIN, 1, ST_OK);
		add_row(OP_INS_AT, -1, 1, TYPED, -1, VALUE_MIN, 2, ST_OK);
		add_row(OP_INS_AT, 5, 3, TYPED, -1, 5, 3, ST_OK);
		// Delete at accepts one to the count; one past it and zero are bad.
		add_row(OP_DEL_AT, 0, 4, TYPED, -1, 5, 3, ST_RANGE);
		add_row(OP_DEL_AT, 0, 0, TYPED, -1, 5, 3, ST_RANGE);
		add_row(OP_DEL_AT, 0, 2, FROM_SHADOW, 0, 0, 0, ST_OK);
		add_row(OP_SPARE_HI, -1, 31, FROM_SHADOW, 0, 0, 0, ST_OK);
		add_row(OP_INS_AT, 32'sh5A5A_5A5A, 2, FROM_SHADOW, 0, 0, 0, ST_OK);
		add_row(OP_DEL_END, 0, 0, FROM_SHADOW, 0, 0, 0, ST_OK);
		add_row(OP_DEL_FRONT, 0, 0, FROM_SHADOW, 0, 0, 0, ST_OK);
		add_row(OP_DEL_AT, 0, 1, TYPED, 0, 0, 0, ST_OK);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_plan[i])
			issue_word(directed_plan[i].opcode, directed_plan[i].value,
				directed_plan[i].position, directed_plan[i].typed, directed_plan[i].view);

		// Random part. The first phase grows the list so that the full corner
		// is reached early; the edge phases fill or drain the list and keep
		// pushing against the limit with many bad positions mixed in.
		while (random_sent < RANDOM_WORDS) begin
			mix = (random_sent == 0) ? MIX_GROW : mix_e'($urandom_range(3));
			phase_left = (mix == MIX_EDGES) ? $urandom_range(64, 30) : $urandom_range(64, 16);
			if (mix == MIX_EDGES)
				grow_edge = ~grow_edge;
			odd_pos_pct = (mix == MIX_EDGES) ? 50 : 10;
			while (phase_left > 0 && random_sent < RANDOM_WORDS) begin
				roll = $urandom_range(99);
				case (mix)
					MIX_GROW:   is_insert = (roll < 78);
					MIX_SHRINK: is_insert = (roll < 25);
					MIX_CHURN:  is_insert = (roll < 52);
					default:    is_insert = grow_edge ? (roll < 90) : (roll < 10);
				endcase
				kind = $urandom_range(2);
				if ($urandom_range(99) < 3)
					op = roll[0] ? OP_SPARE_LO : OP_SPARE_HI;
				else if (is_insert)
					op = (kind == 0) ? OP_INS_FRONT : (kind == 1) ? OP_INS_END : OP_INS_AT;
				else
					op = (kind == 0) ? OP_DEL_FRONT : (kind == 1) ? OP_DEL_END : OP_DEL_AT;

				// Positions are mostly legal for the current count; the rest
				// roam over the whole field.
				if ($urandom_range(99) < odd_pos_pct)
					pos = POS_W'($urandom_range(31));
				else if (op == OP_INS_AT)
					pos = POS_W'($urandom_range(shadow_count + 1, 1));
				else if (op == OP_DEL_AT && shadow_count > 0)
					pos = POS_W'($urandom_range(shadow_count, 1));
				else
					pos = POS_W'($urandom_range(31));

				if ($urandom_range(7) == 0) begin
					case ($urandom_range(3))
						0:       value = VALUE_MAX;
						1:       value = VALUE_MIN;
						2:       value = '0;
						default: value = -1;
					endcase
				end else begin
					value = $urandom;
				end

				issue_word(op, value, pos, FROM_SHADOW, '0);
				random_sent++;
				phase_left--;
			end
		end

		req_ch.valid <= 1'b0;
		while (list_views.size() != 0) @(posedge clk);
		// Wait on so that any stray result word is caught.
		repeat (8) @(posedge clk);

		if (error_count == 0)
			$display("tb_ordered_list_deque_unit: clean");
		else
			$display("tb_ordered_list_deque_unit: errors");
		$finish;
	end

	// Result side: checks each accepted word against the oldest view owed,
	// then picks ready for the next edge from the current stall pattern.
	initial begin : result_sink
		list_view_t want;
		rx_mode_e   rx_mode;
		int         rx_left;
		int         rx_period;
		int         rx_tick;
		logic       next_ready;

		rsp_ch.ready <= 1'b0;
		rx_mode   = RX_FLOW;
		rx_left   = 0;
		rx_period = 2;
		rx_tick   = 0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (list_views.size() == 0) begin
					report_error("result word arrived with nothing expected");
				end else begin
					want = list_views.pop_front();
					if (rsp_ch.front_value !== want.front_value)
						report_error($sformatf("front_value got %0d want %0d",
							rsp_ch.front_value, want.front_value));
					if (rsp_ch.end_value !== want.end_value)
						report_error($sformatf("end_value got %0d want %0d",
							rsp_ch.end_value, want.end_value));
					if (rsp_ch.entry_count !== want.entry_count)
						report_error($sformatf("entry_count got %0d want %0d",
							rsp_ch.entry_count, want.entry_count));
					if (rsp_ch.status !== want.status)
						report_error($sformatf("status got %0d want %0d",
							rsp_ch.status, want.status));
				end
				words_checked++;
			end

			if (rx_left == 0) begin
				rx_mode   = rx_mode_e'($urandom_range(3));
				rx_left   = $urandom_range(200, 20);
				rx_period = $urandom_range(5, 2);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_FLOW:    next_ready = 1'b1;
				RX_CADENCE: next_ready = (rx_tick % rx_period) != 0;
				RX_COIN:    next_ready = ($urandom_range(99) < 55);
				default:    next_ready = (rx_tick % 10) == 0;
			endcase
			rsp_ch.ready <= next_ready;
		end
	end

	// Watchdog: a long run of cycles with no handshake on either channel
	// means the unit has hung or lost a word.
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_ordered_list_deque_unit: errors");
			$finish;
		end
	end

endmodule
